### rtl/core/text_motor_command_with_watchdog_core_assert.svh
// Assertion macros shared by the motor command core.
`ifndef TEXT_MOTOR_COMMAND_WITH_WATCHDOG_CORE_ASSERT_SVH
`define TEXT_MOTOR_COMMAND_WITH_WATCHDOG_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TMC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("motor command core assertion failed");
`define TMC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("motor command core reset assertion failed");
`else
`define TMC_ASSERT(label, prop)
`define TMC_ASSERT_RST(label, prop)
`endif

`endif

### rtl/core/tmc_pkg.sv
package tmc_pkg;

  localparam int MAX_FRAME = 31;
  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  localparam logic [7:0]  MAG_MAX = 8'd255;
  localparam logic [16:0] AGE_MAX = 17'h1FFFF;
  localparam logic [15:0] WATCHDOG_RESET = 16'd500;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_DISC = 2'd2;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam logic [1:0] STAT_NONE   = 2'd0;
  localparam logic [1:0] STAT_ACCEPT = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;

  typedef enum logic [2:0] {
    PH_FIRST_LEAD  = 3'd0,
    PH_FIRST_SIGN  = 3'd1,
    PH_FIRST_DIG   = 3'd2,
    PH_SECOND_LEAD = 3'd3,
    PH_SECOND_SIGN = 3'd4,
    PH_SECOND_DIG  = 3'd5,
    PH_DONE        = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] frame_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       frame_end;
    logic       frame_ok;
    logic       left_neg;
    logic [7:0] left_mag;
    logic       right_neg;
    logic [7:0] right_mag;
  } frame_t;

endpackage

### rtl/core/text_motor_command_with_watchdog_core.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_action, in_frame_byte, in_last_byte
// out       output     out_valid/out_stall  out_right_dir/duty, out_left_dir/duty,
//                                           out_frame_status
// cfg       input      cfg_we               cfg_wdata (watchdog in milliseconds)
//
// One item per cycle while out_stall is low; each item is held in the input register first.
// The parse step and drive update sit between the input register and the result
// register, so throughput is bounded only by the result register being taken.
// Reset is synchronous on rst_n and needs no clearing pass.
// While out_stall holds a full result register, the input register still fills once,
// and in_stall rises only when both are occupied.
module text_motor_command_with_watchdog_core import tmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_right_dir,
  output logic [7:0]  out_right_duty,
  output logic [1:0]  out_left_dir,
  output logic [7:0]  out_left_duty,
  output logic [1:0]  out_frame_status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  item_t  in_item;
  item_t  hold_item;
  logic   hold_valid;
  logic   advance;
  frame_t frame;

  assign in_item = '{action: in_action, frame_byte: in_frame_byte, last_byte: in_last_byte};
  assign advance = hold_valid && (!out_valid || !out_stall);

  tmc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .advance    (advance),
    .in_stall   (in_stall),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  tmc_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (hold_item),
    .frame (frame)
  );

  tmc_command u_command (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (advance),
    .action           (hold_item.action),
    .frame            (frame),
    .out_stall        (out_stall),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_right_dir    (out_right_dir),
    .out_right_duty   (out_right_duty),
    .out_left_dir     (out_left_dir),
    .out_left_duty    (out_left_duty),
    .out_frame_status (out_frame_status)
  );

`include "text_motor_command_with_watchdog_core_assert.svh"

  `TMC_ASSERT(a_stall_needs_held_item, in_stall |-> hold_valid)
  `TMC_ASSERT(a_right_dir_matches_duty, out_valid |-> ((out_right_dir == DIR_STOP) == (out_right_duty == 8'd0)))
  `TMC_ASSERT(a_left_dir_matches_duty, out_valid |-> ((out_left_dir == DIR_STOP) == (out_left_duty == 8'd0)))
  `TMC_ASSERT_RST(a_reset_empties_output, !rst_n |=> !out_valid && !in_stall)

endmodule

### rtl/core/tmc_in_reg.sv
module tmc_in_reg import tmc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  input  logic  advance,
  output logic  in_stall,
  output logic  hold_valid,
  output item_t hold_item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign in_stall = valid_r && !advance;
  assign accept = in_valid && !in_stall;

  always_comb begin
    item_nxt = item_r;
    if (accept) begin
      valid_nxt = 1'b1;
      item_nxt = in_item;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign hold_valid = valid_r;
  assign hold_item = item_r;

endmodule

### rtl/core/tmc_parser.sv
module tmc_parser import tmc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  item_t  item,
  output frame_t frame
);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               fneg_r, fneg_nxt;
  logic [7:0]         fmag_r, fmag_nxt;
  logic               bad_r, bad_nxt;
  logic               ended_r, ended_nxt;
  logic               sneg_r, sneg_nxt;
  logic [7:0]         smag_r, smag_nxt;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D);
  endfunction

  function automatic logic [7:0] accumulate(input logic [7:0] mag, input logic [7:0] c);
    logic [11:0] v;
    v = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {8'h00, c[3:0]};
    return (v > {4'h0, MAG_MAX}) ? MAG_MAX : v[7:0];
  endfunction

  localparam logic [7:0] COMMA = 8'h2C;
  localparam logic [7:0] MINUS = 8'h2D;

  always_comb begin
    logic [7:0] c;
    logic       at_start;
    logic       clear;
    c = item.frame_byte;
    at_start = (count_r == '0);
    clear = 1'b0;
    phase_nxt = phase_r;
    count_nxt = count_r;
    fneg_nxt = fneg_r;
    fmag_nxt = fmag_r;
    bad_nxt = bad_r;
    ended_nxt = ended_r;
    sneg_nxt = sneg_r;
    smag_nxt = smag_r;
    frame = '0;

    if (item.action == ACT_BYTE) begin
      if (count_r < CNT_W'(MAX_FRAME)) begin
        if (!ended_r && !bad_r) begin
          if (c == 8'h00) begin
            ended_nxt = 1'b1;
          end else begin
            unique case (phase_r)
              PH_FIRST_LEAD: begin
                if (is_space(c)) begin
                end else if (is_sign(c)) begin
                  fneg_nxt = (c == MINUS);
                  phase_nxt = PH_FIRST_SIGN;
                end else if (is_digit(c)) begin
                  fmag_nxt = accumulate(fmag_r, c);
                  phase_nxt = PH_FIRST_DIG;
                end else if (c == COMMA && at_start) begin
                  phase_nxt = PH_SECOND_LEAD;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              PH_FIRST_SIGN: begin
                if (is_digit(c)) begin
                  fmag_nxt = accumulate(fmag_r, c);
                  phase_nxt = PH_FIRST_DIG;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              PH_FIRST_DIG: begin
                if (is_digit(c)) begin
                  fmag_nxt = accumulate(fmag_r, c);
                end else if (c == COMMA) begin
                  phase_nxt = PH_SECOND_LEAD;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              PH_SECOND_LEAD: begin
                if (is_space(c)) begin
                end else if (is_sign(c)) begin
                  sneg_nxt = (c == MINUS);
                  phase_nxt = PH_SECOND_SIGN;
                end else if (is_digit(c)) begin
                  smag_nxt = accumulate(smag_r, c);
                  phase_nxt = PH_SECOND_DIG;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              PH_SECOND_SIGN, PH_SECOND_DIG: begin
                if (is_digit(c)) begin
                  smag_nxt = accumulate(smag_r, c);
                  phase_nxt = PH_SECOND_DIG;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        count_nxt = count_r + CNT_W'(1);
      end
      if (item.last_byte) begin
        frame.frame_end = 1'b1;
        frame.frame_ok = !bad_nxt && (phase_nxt >= PH_SECOND_LEAD);
        frame.left_neg = fneg_nxt;
        frame.left_mag = fmag_nxt;
        frame.right_neg = sneg_nxt;
        frame.right_mag = smag_nxt;
        clear = 1'b1;
      end
    end else if (item.action == ACT_DISC) begin
      clear = 1'b1;
    end

    if (clear) begin
      phase_nxt = PH_FIRST_LEAD;
      count_nxt = '0;
      fneg_nxt = 1'b0;
      fmag_nxt = '0;
      bad_nxt = 1'b0;
      ended_nxt = 1'b0;
      sneg_nxt = 1'b0;
      smag_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST_LEAD;
      count_r <= '0;
      fneg_r <= 1'b0;
      fmag_r <= '0;
      bad_r <= 1'b0;
      ended_r <= 1'b0;
      sneg_r <= 1'b0;
      smag_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      fneg_r <= fneg_nxt;
      fmag_r <= fmag_nxt;
      bad_r <= bad_nxt;
      ended_r <= ended_nxt;
      sneg_r <= sneg_nxt;
      smag_r <= smag_nxt;
    end
  end

endmodule

### rtl/core/tmc_command.sv
module tmc_command import tmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [1:0]  action,
  input  frame_t      frame,
  input  logic        out_stall,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic [1:0]  out_right_dir,
  output logic [7:0]  out_right_duty,
  output logic [1:0]  out_left_dir,
  output logic [7:0]  out_left_duty,
  output logic [1:0]  out_frame_status
);

  logic [15:0] wd_r;
  logic        lneg_r, lneg_nxt, rneg_r, rneg_nxt;
  logic [7:0]  lmag_r, lmag_nxt, rmag_r, rmag_nxt;
  logic [16:0] age_r, age_nxt;
  logic        cvalid_r, cvalid_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [1:0]  rdir_r, rdir_nxt, ldir_r, ldir_nxt, stat_r, stat_nxt;
  logic [7:0]  rduty_r, rduty_nxt, lduty_r, lduty_nxt;
  logic        stale;

  function automatic logic [1:0] dir_of(input logic neg, input logic [7:0] mag);
    if (mag == 8'd0) begin
      return DIR_STOP;
    end
    return neg ? DIR_REV : DIR_FWD;
  endfunction

  always_comb begin
    lneg_nxt = lneg_r;
    rneg_nxt = rneg_r;
    lmag_nxt = lmag_r;
    rmag_nxt = rmag_r;
    age_nxt = age_r;
    cvalid_nxt = cvalid_r;
    stat_nxt = STAT_NONE;
    if (action == ACT_BYTE) begin
      if (frame.frame_end) begin
        if (frame.frame_ok) begin
          lneg_nxt = frame.left_neg;
          lmag_nxt = frame.left_mag;
          rneg_nxt = frame.right_neg;
          rmag_nxt = frame.right_mag;
          age_nxt = '0;
          cvalid_nxt = 1'b1;
          stat_nxt = STAT_ACCEPT;
        end else begin
          stat_nxt = STAT_REJECT;
        end
      end
    end else if (action == ACT_TICK) begin
      if (age_r < AGE_MAX) begin
        age_nxt = age_r + 17'd1;
      end
    end else if (action == ACT_DISC) begin
      lneg_nxt = 1'b0;
      lmag_nxt = '0;
      rneg_nxt = 1'b0;
      rmag_nxt = '0;
      age_nxt = '0;
      cvalid_nxt = 1'b0;
    end

    stale = !cvalid_nxt || (age_nxt > {1'b0, wd_r});
    rduty_nxt = stale ? 8'd0 : rmag_nxt;
    lduty_nxt = stale ? 8'd0 : lmag_nxt;
    rdir_nxt = dir_of(rneg_nxt, rduty_nxt);
    ldir_nxt = dir_of(lneg_nxt, lduty_nxt);

    if (step) begin
      ovalid_nxt = 1'b1;
    end else begin
      ovalid_nxt = ovalid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r <= WATCHDOG_RESET;
      lneg_r <= 1'b0;
      lmag_r <= '0;
      rneg_r <= 1'b0;
      rmag_r <= '0;
      age_r <= '0;
      cvalid_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wd_r <= cfg_wdata;
      end
      if (step) begin
        lneg_r <= lneg_nxt;
        lmag_r <= lmag_nxt;
        rneg_r <= rneg_nxt;
        rmag_r <= rmag_nxt;
        age_r <= age_nxt;
        cvalid_r <= cvalid_nxt;
      end
      ovalid_r <= ovalid_nxt;
    end
    if (step) begin
      rdir_r <= rdir_nxt;
      rduty_r <= rduty_nxt;
      ldir_r <= ldir_nxt;
      lduty_r <= lduty_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_right_dir = rdir_r;
  assign out_right_duty = rduty_r;
  assign out_left_dir = ldir_r;
  assign out_left_duty = lduty_r;
  assign out_frame_status = stat_r;

endmodule
